/* src/assert_macros.svh */
// Assertion macros for the checker file of the key schedule block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sm4ks_pkg.sv */
// Constants, tables and round functions of the SM4 key schedule.
package sm4ks_pkg;

  localparam int ROUNDS = 32;
  localparam int RIDX_W = $clog2(ROUNDS);

  localparam logic [31:0] FK [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Byte j of CK[i], counted from the top byte, is (4*i + j) * 7 mod 256.
  function automatic logic [31:0] ck_word(input logic [RIDX_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  base;
    logic [7:0]  pos;
    base = 8'({i, 2'b00});
    for (int j = 0; j < 4; j++) begin
      pos = base + 8'(j);
      w[8*(3-j) +: 8] = 8'(pos * 8'd7);
    end
    return w;
  endfunction

  // S-box on every byte, then x ^ rotl(x,13) ^ rotl(x,23).
  function automatic logic [31:0] t_prime(input logic [31:0] x);
    logic [31:0] b;
    for (int j = 0; j < 4; j++) begin
      b[8*j +: 8] = SBOX[x[8*j +: 8]];
    end
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

endpackage

/* src/sm4ks_if.sv */
// Valid/ready channels for master key requests and round key results.
interface sm4ks_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        func;

  modport source (output valid, key_high, key_low, func, input ready);
  modport sink (input valid, key_high, key_low, func, output ready);
endinterface

interface sm4ks_rk_if import sm4ks_pkg::*;;
  logic              valid;
  logic              ready;
  logic [31:0]       round_key;
  logic [RIDX_W-1:0] round_index;
  logic              last_key;

  modport source (output valid, round_key, round_index, last_key, input ready);
  modport sink (input valid, round_key, round_index, last_key, output ready);
endinterface

/* src/sm4ks_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sm4ks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while re is low, which lets the output stage stall.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sm4_round_key_expansion_core.sv */
// SM4 key schedule: expands one master key into 32 round keys held in a RAM.
//
//   channel  role    payload
//   key      sink    key_high[63:0], key_low[63:0], func
//   rkey     source  round_key[31:0], round_index[4:0], last_key
//
// A request is taken only while the sequencer is idle. One round of the
// schedule runs per cycle through the S-box and linear mix and is written
// to the key RAM; the keys then leave at one per cycle while rkey is not
// stalled, through the RAM read port, in either order.
// Reset is synchronous; no clearing pass. A stall on rkey freezes the read
// pipeline; the next request may be taken while the last keys of the
// previous one still drain.
module sm4_round_key_expansion_core import sm4ks_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  sm4ks_key_if.sink      key,
  sm4ks_rk_if.source     rkey
);

  typedef enum logic [1:0] {
    IDLE,
    GEN,
    EMIT
  } state_t;

  localparam logic [RIDX_W-1:0] LAST = RIDX_W'(ROUNDS - 1);

  state_t            state;
  logic [RIDX_W-1:0] cnt;
  logic              dec;
  logic [31:0]       w [4];
  logic              rd_valid;
  logic [RIDX_W-1:0] rd_index;
  logic              rd_last;
  logic              out_valid;
  logic [31:0]       out_key;
  logic [RIDX_W-1:0] out_index;
  logic              out_last;

  logic [31:0]       nk;
  logic              advance;
  logic              issue;
  logic [RIDX_W-1:0] raddr;
  logic [31:0]       rdata;
  logic [RIDX_W-1:0] cnt_next;

  assign nk       = w[0] ^ t_prime(w[1] ^ w[2] ^ w[3] ^ ck_word(cnt));
  assign advance  = !out_valid || rkey.ready;
  assign issue    = (state == EMIT) && advance;
  assign raddr    = dec ? (LAST - cnt) : cnt;
  assign cnt_next = (cnt == LAST) ? '0 : cnt + 1'b1;

  sm4ks_ram #(
    .WIDTH(32),
    .DEPTH(ROUNDS)
  ) u_key_ram (
    .clk  (clk),
    .we   (state == GEN),
    .waddr(cnt),
    .wdata(nk),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (key.valid) begin
            w[0]  <= key.key_high[63:32] ^ FK[0];
            w[1]  <= key.key_high[31:0] ^ FK[1];
            w[2]  <= key.key_low[63:32] ^ FK[2];
            w[3]  <= key.key_low[31:0] ^ FK[3];
            dec   <= key.func;
            cnt   <= '0;
            state <= GEN;
          end
        end
        GEN: begin
          w[0] <= w[1];
          w[1] <= w[2];
          w[2] <= w[3];
          w[3] <= nk;
          cnt  <= cnt_next;
          if (cnt == LAST) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (advance) begin
            cnt <= cnt_next;
            if (cnt == LAST) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      // Two-stage read pipeline: RAM data register, then output register.
      if (advance) begin
        rd_valid  <= issue;
        out_valid <= rd_valid;
        out_key   <= rdata;
        out_index <= rd_index;
        out_last  <= rd_last;
      end
      if (issue) begin
        rd_index <= cnt;
        rd_last  <= (cnt == LAST);
      end
    end
  end

  assign key.ready        = (state == IDLE);
  assign rkey.valid       = out_valid;
  assign rkey.round_key   = out_key;
  assign rkey.round_index = out_index;
  assign rkey.last_key    = out_last;

endmodule

/* src/sm4ks_checker.sv */
// Port-level checker for the SM4 key schedule, bound to the top level.
`include "assert_macros.svh"

module sm4ks_checker import sm4ks_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [31:0]       round_key,
  input logic [RIDX_W-1:0] round_index,
  input logic              last_key
);

  logic [RIDX_W-1:0] exp_index;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Counts delivered round keys; wraps once per master key.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_index <= '0;
    end else if (out_acc) begin
      exp_index <= exp_index + 1'b1;
    end
  end

  `CHK_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(round_key) && $stable(round_index) && $stable(last_key), "stalled round key changed")
  `CHK_IMPLY(a_index_order, clk, rst, out_acc, round_index == exp_index, "round index out of sequence")
  `CHK_IMPLY(a_last_flag, clk, rst, out_valid, last_key == (round_index == RIDX_W'(ROUNDS - 1)), "last key flag misplaced")
  `CHK_NEXT(a_one_key, clk, rst, in_acc, !in_ready, "second key request taken during expansion")

endmodule

bind sm4_round_key_expansion_core sm4ks_checker u_sm4ks_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (key.valid),
  .in_ready   (key.ready),
  .out_valid  (rkey.valid),
  .out_ready  (rkey.ready),
  .round_key  (rkey.round_key),
  .round_index(rkey.round_index),
  .last_key   (rkey.last_key)
);
